// ===== rtl/core/sensor_alert_priority_tracker_top_assert.svh =====
// Assertion macros shared by the sensor alert priority tracker modules.
`ifndef SENSOR_ALERT_PRIORITY_TRACKER_TOP_ASSERT_SVH
`define SENSOR_ALERT_PRIORITY_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define SAPT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define SAPT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sapt_pkg.sv =====
// Package with the types, constants and helper functions of the alert tracker.
package sapt_pkg;

  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned NUM_SENSORS = 6;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned NUM_REGS    = 3;
  localparam int unsigned REG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [2:0]           sensor_t;
  typedef logic [2:0]           code_t;
  typedef logic [3:0]           tone_t;
  typedef logic [2:0]           count_t;
  typedef logic [CFG_W-1:0]     cfg_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  // Register indexes on the configuration port.
  localparam reg_idx_t REG_NOTICE_HOLD  = 2'd0;
  localparam reg_idx_t REG_GEN_COOLDOWN = 2'd1;
  localparam reg_idx_t REG_SOIL_COOLDOWN = 2'd2;

  localparam cfg_t NOTICE_HOLD_RST   = 16'd1800;
  localparam cfg_t GEN_COOLDOWN_RST  = 16'd1200;
  localparam cfg_t SOIL_COOLDOWN_RST = 16'd1800;

  // Sensor numbers.
  localparam sensor_t SENS_TEMP     = 3'd0;
  localparam sensor_t SENS_HUMIDITY = 3'd1;
  localparam sensor_t SENS_LIGHT    = 3'd2;
  localparam sensor_t SENS_SOUND    = 3'd3;
  localparam sensor_t SENS_SOIL     = 3'd4;
  localparam sensor_t SENS_PROBE    = 3'd5;

  // Alert codes.
  localparam code_t CODE_OFF      = 3'd0;
  localparam code_t CODE_OK       = 3'd1;
  localparam code_t CODE_LOW      = 3'd2;
  localparam code_t CODE_HIGH     = 3'd3;
  localparam code_t CODE_CRITICAL = 3'd4;
  localparam code_t CODE_MOIST    = 3'd5;

  // Tone numbers.
  localparam tone_t TONE_NONE          = 4'd0;
  localparam tone_t TONE_TEMP_LOW      = 4'd1;
  localparam tone_t TONE_TEMP_HIGH     = 4'd2;
  localparam tone_t TONE_HUM_LOW       = 4'd3;
  localparam tone_t TONE_HUM_HIGH      = 4'd4;
  localparam tone_t TONE_LIGHT_LOW     = 4'd5;
  localparam tone_t TONE_LIGHT_HIGH    = 4'd6;
  localparam tone_t TONE_SOIL_LOW      = 4'd7;
  localparam tone_t TONE_SOIL_OK       = 4'd8;
  localparam tone_t TONE_SOIL_CRITICAL = 4'd9;
  localparam tone_t TONE_PROBE_LOW     = 4'd10;
  localparam tone_t TONE_PROBE_HIGH    = 4'd11;

  // Tie-break weight per sensor: larger wins. Order is soil, temp, humidity,
  // probe temp, light, sound.
  localparam logic [2:0] TIE_WEIGHT [NUM_SENSORS] = '{3'd4, 3'd3, 3'd1, 3'd0, 3'd5, 3'd2};

  // Work handed from the front to the back through the queue.
  typedef struct packed {
    logic                        changed;
    logic                        entered;
    logic                        exited;
    tone_t                       tone;
    logic                        refresh;
    time_t                       now;
    code_t [NUM_SENSORS-1:0]     codes;
  } job_t;

  function automatic logic is_active(code_t c);
    return (c == CODE_LOW) || (c == CODE_HIGH) || (c == CODE_CRITICAL) ||
           (c == CODE_MOIST);
  endfunction

  function automatic logic [1:0] severity(code_t c);
    logic [1:0] s;
    case (c)
      CODE_CRITICAL:         s = 2'd3;
      CODE_HIGH:             s = 2'd2;
      CODE_LOW, CODE_MOIST:  s = 2'd1;
      default:               s = 2'd0;
    endcase
    return s;
  endfunction

  // True when time a lies strictly before time b, modulo the time width.
  function automatic logic is_earlier(time_t a, time_t b);
    time_t d;
    d = a - b;
    return d[TIME_BITS-1];
  endfunction

  function automatic tone_t tone_for(sensor_t s, code_t c);
    tone_t t;
    t = TONE_NONE;
    case (s)
      SENS_TEMP: begin
        if (c == CODE_LOW) t = TONE_TEMP_LOW;
        else if (c == CODE_HIGH) t = TONE_TEMP_HIGH;
      end
      SENS_HUMIDITY: begin
        if (c == CODE_LOW) t = TONE_HUM_LOW;
        else if (c == CODE_HIGH) t = TONE_HUM_HIGH;
      end
      SENS_LIGHT: begin
        if (c == CODE_LOW) t = TONE_LIGHT_LOW;
        else if (c == CODE_HIGH) t = TONE_LIGHT_HIGH;
      end
      SENS_SOIL: begin
        if (c == CODE_LOW) t = TONE_SOIL_LOW;
        else if (c == CODE_OK) t = TONE_SOIL_OK;
        else if (c == CODE_CRITICAL) t = TONE_SOIL_CRITICAL;
      end
      SENS_PROBE: begin
        if (c == CODE_LOW) t = TONE_PROBE_LOW;
        else if (c == CODE_HIGH) t = TONE_PROBE_HIGH;
      end
      default: t = TONE_NONE;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/core/sapt_if.sv =====
// Channel interfaces for the alert update input and the status result output.
interface sapt_in_if;
  logic              valid;
  logic              ready;
  sapt_pkg::sensor_t sensor_id;
  sapt_pkg::code_t   alert_code;
  logic              screen_switch;
  logic              sound_on;
  logic              refresh_summary;
  logic [31:0]       now_ms;

  modport source (output valid, sensor_id, alert_code, screen_switch, sound_on,
                  refresh_summary, now_ms, input ready);
  modport sink (input valid, sensor_id, alert_code, screen_switch, sound_on,
                refresh_summary, now_ms, output ready);
endinterface

interface sapt_out_if;
  logic              valid;
  logic              ready;
  logic              code_changed;
  logic              alert_entered;
  logic              alert_exited;
  logic              any_active;
  sapt_pkg::sensor_t top_sensor;
  sapt_pkg::code_t   top_code;
  sapt_pkg::count_t  others_active;
  logic              notice_shown;
  sapt_pkg::sensor_t notice_sensor;
  sapt_pkg::code_t   notice_code;
  sapt_pkg::count_t  notice_others;
  sapt_pkg::tone_t   tone_id;

  modport source (output valid, code_changed, alert_entered, alert_exited, any_active,
                  top_sensor, top_code, others_active, notice_shown,
                  notice_sensor, notice_code, notice_others, tone_id, input ready);
  modport sink (input valid, code_changed, alert_entered, alert_exited, any_active,
                top_sensor, top_code, others_active, notice_shown,
                notice_sensor, notice_code, notice_others, tone_id, output ready);
endinterface

// ===== rtl/core/sapt_front.sv =====
// Front stage: accepts updates, keeps sensor codes and tone cooldowns.
`include "sensor_alert_priority_tracker_top_assert.svh"

module sapt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  sapt_in_if.sink        in_i,
  input  sapt_pkg::cfg_t gen_cooldown_i,
  input  sapt_pkg::cfg_t soil_cooldown_i,
  input  logic           push_ready_i,
  output logic           push_o,
  output sapt_pkg::job_t job_o
);

  sapt_pkg::code_t   codes_q [sapt_pkg::NUM_SENSORS];
  sapt_pkg::code_t   codes_d [sapt_pkg::NUM_SENSORS];
  sapt_pkg::time_t   last_tone_q [sapt_pkg::NUM_SENSORS];

  logic              accept;
  logic              id_ok;
  sapt_pkg::sensor_t idx;
  sapt_pkg::code_t   prev_code;
  sapt_pkg::time_t   now_t;
  sapt_pkg::time_t   last_t;
  sapt_pkg::time_t   elapsed;
  sapt_pkg::cfg_t    cooldown;
  logic              changed;
  logic              tone_ok;

  assign in_i.ready = push_ready_i;
  assign accept     = in_i.valid && push_ready_i;
  assign push_o     = accept;

  assign idx   = in_i.sensor_id;
  assign id_ok = (idx < sapt_pkg::sensor_t'(sapt_pkg::NUM_SENSORS));
  assign now_t = sapt_pkg::TIME_BITS'(in_i.now_ms);

  always_comb begin
    prev_code = sapt_pkg::CODE_OFF;
    last_t    = '0;
    for (int i = 0; i < sapt_pkg::NUM_SENSORS; i++) begin
      if (idx == sapt_pkg::sensor_t'(i)) begin
        prev_code = codes_q[i];
        last_t    = last_tone_q[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < sapt_pkg::NUM_SENSORS; i++) begin
      codes_d[i] = (idx == sapt_pkg::sensor_t'(i)) ? in_i.alert_code : codes_q[i];
    end
  end

  assign changed  = id_ok && !in_i.screen_switch && (prev_code != in_i.alert_code);
  assign cooldown = (idx == sapt_pkg::SENS_SOIL) ? soil_cooldown_i : gen_cooldown_i;
  assign elapsed  = now_t - last_t;
  // A zero cooldown disables the tone altogether.
  assign tone_ok  = in_i.sound_on && changed && (idx != sapt_pkg::SENS_SOUND) &&
                    (cooldown != '0) && (elapsed >= sapt_pkg::TIME_BITS'(cooldown));

  always_comb begin
    job_o.changed = changed;
    job_o.entered = changed && (in_i.alert_code != sapt_pkg::CODE_OFF);
    job_o.exited  = changed && (prev_code != sapt_pkg::CODE_OFF) &&
                    (in_i.alert_code == sapt_pkg::CODE_OFF);
    job_o.tone    = tone_ok ? sapt_pkg::tone_for(idx, in_i.alert_code) : sapt_pkg::TONE_NONE;
    job_o.refresh = in_i.refresh_summary;
    job_o.now     = now_t;
    for (int i = 0; i < sapt_pkg::NUM_SENSORS; i++) begin
      job_o.codes[i] = codes_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sapt_pkg::NUM_SENSORS; i++) begin
        codes_q[i]     <= sapt_pkg::CODE_OFF;
        last_tone_q[i] <= '0;
      end
    end else if (accept) begin
      for (int i = 0; i < sapt_pkg::NUM_SENSORS; i++) begin
        codes_q[i] <= codes_d[i];
        if (tone_ok && (idx == sapt_pkg::sensor_t'(i))) begin
          last_tone_q[i] <= now_t;
        end
      end
    end
  end

  `SAPT_ASSERT_IMP(a_tone_needs_change, job_o.tone != sapt_pkg::TONE_NONE, job_o.changed, "tone without a code change")
  `SAPT_ASSERT_IMP(a_sound_silent, idx == sapt_pkg::SENS_SOUND, job_o.tone == sapt_pkg::TONE_NONE, "sound sensor produced a tone")

endmodule

// ===== rtl/core/sapt_queue.sv =====
// Short job queue between the front and back stages.
`include "sensor_alert_priority_tracker_top_assert.svh"

module sapt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sapt_pkg::job_t job_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output sapt_pkg::job_t job_o
);

  localparam logic [sapt_pkg::QPTR_W-1:0] LAST_PTR =
    sapt_pkg::QPTR_W'(sapt_pkg::QUEUE_DEPTH - 1);
  localparam logic [sapt_pkg::QCNT_W-1:0] FULL_CNT =
    sapt_pkg::QCNT_W'(sapt_pkg::QUEUE_DEPTH);

  sapt_pkg::job_t                entries_q [sapt_pkg::QUEUE_DEPTH];
  logic [sapt_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [sapt_pkg::QCNT_W-1:0]   count_q;

  assign ready_o = (count_q != FULL_CNT);
  assign valid_o = (count_q != '0);
  assign job_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `SAPT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= FULL_CNT, "queue count above depth")
  `SAPT_ASSERT_IMP(a_no_overflow, push_i, ready_o, "push into a full queue")

endmodule

// ===== rtl/core/sapt_back.sv =====
// Back stage: ranks active alerts, tracks the entry notice, registers results.
`include "sensor_alert_priority_tracker_top_assert.svh"

module sapt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  sapt_pkg::job_t job_i,
  output logic           pop_o,
  input  sapt_pkg::cfg_t notice_hold_i,
  sapt_out_if.source     out_o
);

  logic              sum_active_q, sum_active_d;
  sapt_pkg::sensor_t sum_sensor_q, sum_sensor_d;
  sapt_pkg::code_t   sum_code_q, sum_code_d;
  sapt_pkg::count_t  sum_others_q, sum_others_d;
  logic              note_active_q, note_active_d;
  sapt_pkg::sensor_t note_sensor_q, note_sensor_d;
  sapt_pkg::code_t   note_code_q, note_code_d;
  sapt_pkg::count_t  note_others_q, note_others_d;
  sapt_pkg::time_t   note_deadline_q, note_deadline_d;

  logic              out_valid_q;
  logic              changed_q, entered_q, exited_q, shown_q;
  sapt_pkg::tone_t   tone_q;

  logic              act;
  sapt_pkg::sensor_t best_sensor;
  sapt_pkg::code_t   best_code;
  logic [4:0]        best_key;
  logic [4:0]        key;
  sapt_pkg::count_t  active_cnt;
  logic              primary_moved;

  assign pop_o = valid_i && (!out_valid_q || out_o.ready);

  // Ranking key is severity above the fixed sensor tie-break weight.
  always_comb begin
    act         = 1'b0;
    best_sensor = sapt_pkg::SENS_TEMP;
    best_code   = sapt_pkg::CODE_OFF;
    best_key    = '0;
    active_cnt  = '0;
    key         = '0;
    for (int i = 0; i < sapt_pkg::NUM_SENSORS; i++) begin
      key = {sapt_pkg::severity(job_i.codes[i]), sapt_pkg::TIE_WEIGHT[i]};
      if (sapt_pkg::is_active(job_i.codes[i])) begin
        active_cnt = active_cnt + 3'd1;
        if (!act || (key > best_key)) begin
          best_key    = key;
          best_sensor = sapt_pkg::sensor_t'(i);
          best_code   = job_i.codes[i];
        end
        act = 1'b1;
      end
    end
  end

  assign primary_moved = (act != sum_active_q) || (best_sensor != sum_sensor_q) ||
                         (best_code != sum_code_q);

  always_comb begin
    sum_active_d    = sum_active_q;
    sum_sensor_d    = sum_sensor_q;
    sum_code_d      = sum_code_q;
    sum_others_d    = sum_others_q;
    note_active_d   = note_active_q;
    note_sensor_d   = note_sensor_q;
    note_code_d     = note_code_q;
    note_others_d   = note_others_q;
    note_deadline_d = note_deadline_q;
    if (job_i.refresh) begin
      sum_active_d = act;
      sum_sensor_d = best_sensor;
      sum_code_d   = best_code;
      sum_others_d = act ? active_cnt - 3'd1 : '0;
      if (act && primary_moved) begin
        note_active_d   = 1'b1;
        note_sensor_d   = best_sensor;
        note_code_d     = best_code;
        note_others_d   = act ? active_cnt - 3'd1 : '0;
        note_deadline_d = job_i.now + sapt_pkg::TIME_BITS'(notice_hold_i);
      end else if (!(act && note_active_q &&
                     sapt_pkg::is_earlier(job_i.now, note_deadline_q))) begin
        note_active_d   = 1'b0;
        note_sensor_d   = '0;
        note_code_d     = '0;
        note_others_d   = '0;
        note_deadline_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_active_q    <= 1'b0;
      sum_sensor_q    <= sapt_pkg::SENS_TEMP;
      sum_code_q      <= sapt_pkg::CODE_OFF;
      sum_others_q    <= '0;
      note_active_q   <= 1'b0;
      note_sensor_q   <= '0;
      note_code_q     <= '0;
      note_others_q   <= '0;
      note_deadline_q <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (pop_o) begin
        sum_active_q    <= sum_active_d;
        sum_sensor_q    <= sum_sensor_d;
        sum_code_q      <= sum_code_d;
        sum_others_q    <= sum_others_d;
        note_active_q   <= note_active_d;
        note_sensor_q   <= note_sensor_d;
        note_code_q     <= note_code_d;
        note_others_q   <= note_others_d;
        note_deadline_q <= note_deadline_d;
        out_valid_q     <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      changed_q <= job_i.changed;
      entered_q <= job_i.entered;
      exited_q  <= job_i.exited;
      tone_q    <= job_i.tone;
      shown_q   <= note_active_d && sapt_pkg::is_earlier(job_i.now, note_deadline_d);
    end
  end

  // Summary and notice fields come straight from the state registers.
  assign out_o.valid          = out_valid_q;
  assign out_o.code_changed   = changed_q;
  assign out_o.alert_entered  = entered_q;
  assign out_o.alert_exited   = exited_q;
  assign out_o.any_active     = sum_active_q;
  assign out_o.top_sensor     = sum_sensor_q;
  assign out_o.top_code       = sum_code_q;
  assign out_o.others_active  = sum_others_q;
  assign out_o.notice_shown   = shown_q;
  assign out_o.notice_sensor  = note_sensor_q;
  assign out_o.notice_code    = note_code_q;
  assign out_o.notice_others  = note_others_q;
  assign out_o.tone_id        = tone_q;

  `SAPT_ASSERT_IMP(a_idle_summary, !sum_active_q, (sum_sensor_q == sapt_pkg::SENS_TEMP) && (sum_code_q == sapt_pkg::CODE_OFF) && !note_active_q, "inactive summary not cleared")
  `SAPT_ASSERT_NXT(a_hold_result, out_valid_q && !out_o.ready, out_valid_q, "pending result dropped")

endmodule

// ===== rtl/core/sensor_alert_priority_tracker_top.sv =====
// Top level of the sensor alert priority tracker: configuration and stage wiring.
//
// Each input transaction carries one sensor's new alert code with a millisecond
// timestamp and produces exactly one result transaction. The block takes one
// transaction per clock cycle while the queue has room; its result passes through
// the queue and the output register. The front stage updates the six stored
// codes and the per-sensor tone cooldown stamps in the cycle the transaction is
// accepted, so the next transaction can follow in the very next cycle. A two-entry
// queue carries the update, along with a snapshot of all six codes, to the back
// stage, which ranks the active alerts, maintains the primary summary and the
// timed entry notice, and holds the result in an output register. Either side
// may stall on its own: the input is accepted while the queue has room, even when
// a finished result is still waiting. Configuration registers (notice hold,
// general and soil cooldowns, in milliseconds) are written through the plain write
// port and should only change while no transaction is in flight. Timestamps wrap;
// the notice deadline test uses the sign of the wrapped difference.

module sensor_alert_priority_tracker_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  sapt_in_if.sink            in_i,
  sapt_out_if.source         out_o,
  input  logic               cfg_we_i,
  input  sapt_pkg::reg_idx_t cfg_idx_i,
  input  sapt_pkg::cfg_t     cfg_wdata_i
);

  sapt_pkg::cfg_t notice_hold_q;
  sapt_pkg::cfg_t gen_cooldown_q;
  sapt_pkg::cfg_t soil_cooldown_q;

  logic           push;
  logic           push_ready;
  sapt_pkg::job_t front_job;
  logic           pop;
  logic           queue_valid;
  sapt_pkg::job_t queue_job;

  // Configuration registers; a write to an unused index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      notice_hold_q   <= sapt_pkg::NOTICE_HOLD_RST;
      gen_cooldown_q  <= sapt_pkg::GEN_COOLDOWN_RST;
      soil_cooldown_q <= sapt_pkg::SOIL_COOLDOWN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sapt_pkg::REG_NOTICE_HOLD:   notice_hold_q   <= cfg_wdata_i;
        sapt_pkg::REG_GEN_COOLDOWN:  gen_cooldown_q  <= cfg_wdata_i;
        sapt_pkg::REG_SOIL_COOLDOWN: soil_cooldown_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Front stage: code store, change events and tone cooldown.
  sapt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_i            (in_i),
    .gen_cooldown_i  (gen_cooldown_q),
    .soil_cooldown_i (soil_cooldown_q),
    .push_ready_i    (push_ready),
    .push_o          (push),
    .job_o           (front_job)
  );

  // Decoupling queue between the stages.
  sapt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .ready_o (push_ready),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .job_o   (queue_job)
  );

  // Back stage: ranking, summary, entry notice and the output register.
  sapt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (queue_valid),
    .job_i         (queue_job),
    .pop_o         (pop),
    .notice_hold_i (notice_hold_q),
    .out_o         (out_o)
  );

endmodule
